// File: hdl/bmpu_pkg.sv
// Shared types, codes and defaults of the BMP row pixel unpacker.
`timescale 1ns / 1ps

package bmpu_pkg;

  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int BYTE_W  = 8;
  localparam int RGB_W   = 24;
  localparam int ARGB_W  = 32;
  localparam int FMT_W   = 3;
  localparam int LW_W    = 13;
  localparam int COUNT_W = 4;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Pixel format register codes; code seven is handled like bgra32.
  typedef enum logic [FMT_W-1:0] {
    FMT_1BPP   = 3'd0,
    FMT_4BPP   = 3'd1,
    FMT_8BPP   = 3'd2,
    FMT_RGB555 = 3'd3,
    FMT_RGB565 = 3'd4,
    FMT_BGR24  = 3'd5,
    FMT_BGRA32 = 3'd6
  } fmt_t;

  typedef enum logic [0:0] {
    CFG_PIXEL_FORMAT = 1'b0,
    CFG_LINE_WIDTH   = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_PIXEL   = 1'b0,
    OP_PALETTE = 1'b1
  } op_t;

  // How the sequencer turns a byte into pixels.
  typedef enum logic [1:0] {
    KIND_1BPP   = 2'd0,
    KIND_4BPP   = 2'd1,
    KIND_8BPP   = 2'd2,
    KIND_DIRECT = 2'd3
  } kind_t;

  // Work handed from the row tracker to the pixel sequencer for one byte.
  typedef struct packed {
    logic [COUNT_W-1:0] count;    // pixels this byte yields, 0 to 8
    kind_t              kind;
    logic               row_end;  // the last pixel of the run closes the row
    logic [ARGB_W-1:0]  direct;   // finished pixel for the direct formats
  } run_req_t;

endpackage

// File: hdl/bmpu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bmpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/bmpu_row_ctl.sv
// Row position tracking and per-byte decode of the pixel count and direct colors.
`timescale 1ns / 1ps

module bmpu_row_ctl #(
  parameter int MAX_WIDTH = bmpu_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           restart,
  input  logic                           byte_accept,
  input  logic [bmpu_pkg::FMT_W-1:0]     pixel_format,
  input  logic [bmpu_pkg::LW_W-1:0]      line_width,
  input  logic [bmpu_pkg::BYTE_W-1:0]    data_byte,
  output bmpu_pkg::run_req_t             req
);

  import bmpu_pkg::*;

  localparam int PCW = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (PCW > LW_W) ? PCW : LW_W;
  localparam int SW  = EW + 3;

  logic [EW-1:0]    pc_r, pc_nxt;
  logic [SW-1:0]    bc_r, bc_nxt;
  logic [RGB_W-1:0] partial_r, partial_nxt;
  logic [1:0]       phase_r, phase_nxt;

  logic [EW-1:0]    width;
  logic [EW-1:0]    rem;
  logic [EW+4:0]    row_bits;
  logic [EW+5:0]    row_bits_up;
  logic [SW-1:0]    stride;
  logic [SW-1:0]    bc_inc;
  logic [2:0]       nbytes;
  logic [ARGB_W-1:0] v;

  always_comb begin
    // Effective width: zero acts as one, the top is clamped.
    if (line_width == '0) begin
      width = EW'(1);
    end else if (EW'(line_width) > EW'(MAX_WIDTH)) begin
      width = EW'(MAX_WIDTH);
    end else begin
      width = EW'(line_width);
    end

    unique case (pixel_format)
      FMT_1BPP:   row_bits = (EW+5)'(width);
      FMT_4BPP:   row_bits = (EW+5)'(width) << 2;
      FMT_8BPP:   row_bits = (EW+5)'(width) << 3;
      FMT_RGB555,
      FMT_RGB565: row_bits = (EW+5)'(width) << 4;
      FMT_BGR24:  row_bits = ((EW+5)'(width) << 4) + ((EW+5)'(width) << 3);
      default:    row_bits = (EW+5)'(width) << 5;
    endcase
    row_bits_up = (EW+6)'(row_bits) + (EW+6)'(31);
    stride      = {row_bits_up[EW+5:5], 2'b00};

    unique case (pixel_format)
      FMT_RGB555, FMT_RGB565: nbytes = 3'd2;
      FMT_BGR24:              nbytes = 3'd3;
      default:                nbytes = 3'd4;
    endcase

    rem = width - pc_r;
    v   = {8'h00, partial_r} | (ARGB_W'(data_byte) << {phase_r, 3'b000});

    req         = '0;
    req.kind    = KIND_DIRECT;
    pc_nxt      = pc_r;
    partial_nxt = partial_r;
    phase_nxt   = phase_r;

    if (pc_r < width) begin
      unique case (pixel_format)
        FMT_1BPP: begin
          req.kind  = KIND_1BPP;
          req.count = (rem >= EW'(8)) ? COUNT_W'(8) : rem[COUNT_W-1:0];
        end
        FMT_4BPP: begin
          req.kind  = KIND_4BPP;
          req.count = (rem >= EW'(2)) ? COUNT_W'(2) : COUNT_W'(1);
        end
        FMT_8BPP: begin
          req.kind  = KIND_8BPP;
          req.count = COUNT_W'(1);
        end
        default: begin
          if ({1'b0, phase_r} + 3'd1 >= nbytes) begin
            req.count   = COUNT_W'(1);
            partial_nxt = '0;
            phase_nxt   = '0;
            unique case (pixel_format)
              FMT_RGB555: req.direct = {ALPHA_OPAQUE, v[14:10], 3'b000, v[9:5], 3'b000,
                                        v[4:0], 3'b000};
              FMT_RGB565: req.direct = {ALPHA_OPAQUE, v[15:11], 3'b000, v[10:5], 2'b00,
                                        v[4:0], 3'b000};
              FMT_BGR24:  req.direct = {ALPHA_OPAQUE, v[23:0]};
              default:    req.direct = v;
            endcase
          end else begin
            partial_nxt = v[RGB_W-1:0];
            phase_nxt   = phase_r + 2'd1;
          end
        end
      endcase
      req.row_end = (EW'(req.count) == rem);
      pc_nxt      = pc_r + EW'(req.count);
    end

    bc_inc = bc_r + SW'(1);
    bc_nxt = bc_inc;
    if (bc_inc >= stride) begin
      bc_nxt      = '0;
      pc_nxt      = '0;
      partial_nxt = '0;
      phase_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      pc_r      <= '0;
      bc_r      <= '0;
      partial_r <= '0;
      phase_r   <= '0;
    end else if (byte_accept) begin
      pc_r      <= pc_nxt;
      bc_r      <= bc_nxt;
      partial_r <= partial_nxt;
      phase_r   <= phase_nxt;
    end
  end

endmodule

// File: hdl/bmpu_run_seq.sv
// Run register that emits one pixel per cycle while the output is not stalled, palette RAM and result register.
`timescale 1ns / 1ps

module bmpu_run_seq #(
  parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          load_is_write,
  input  bmpu_pkg::run_req_t            load_req,
  input  logic [bmpu_pkg::BYTE_W-1:0]   load_byte,
  input  logic [bmpu_pkg::BYTE_W-1:0]   load_index,
  input  logic [bmpu_pkg::RGB_W-1:0]    load_rgb,
  output logic                          can_load,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmpu_pkg::ARGB_W-1:0]   out_pixel,
  output logic                          out_last_run,
  output logic                          out_last_row
);

  import bmpu_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic              run_valid_r;
  logic              run_write_r;
  run_req_t          run_req_r;
  logic [BYTE_W-1:0] run_byte_r;
  logic [BYTE_W-1:0] run_index_r;
  logic [RGB_W-1:0]  run_rgb_r;
  logic [2:0]        k_r;

  logic              res_valid_r;
  logic              res_pal_r;
  logic              res_oor_r;
  logic [ARGB_W-1:0] res_direct_r;
  logic              res_last_run_r;
  logic              res_last_row_r;

  logic              advance;
  logic              emit;
  logic              last_k;
  logic              done;
  logic [BYTE_W-1:0] rd_index;
  logic              rd_oor;
  logic              wr_en;
  logic [RGB_W-1:0]  rdata;

  always_comb begin
    unique case (run_req_r.kind)
      KIND_1BPP: rd_index = {7'b0, run_byte_r[3'd7 - k_r]};
      KIND_4BPP: rd_index = k_r[0] ? {4'b0, run_byte_r[3:0]} : {4'b0, run_byte_r[7:4]};
      KIND_8BPP: rd_index = run_byte_r;
      default:   rd_index = run_byte_r;
    endcase
    rd_oor  = ({1'b0, rd_index} >= 9'(PALETTE_DEPTH));
    advance = !res_valid_r || out_ready;
    emit    = run_valid_r && !run_write_r && advance;
    last_k  = ({1'b0, k_r} == run_req_r.count - COUNT_W'(1));
    done    = run_valid_r && (run_write_r || (emit && last_k));
    wr_en   = run_valid_r && run_write_r && ({1'b0, run_index_r} < 9'(PALETTE_DEPTH));
  end

  assign can_load = !run_valid_r || done;

  bmpu_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (run_index_r[AW-1:0]),
    .wdata (run_rgb_r),
    .re    (emit),
    .raddr (rd_index[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      k_r         <= '0;
    end else if (load) begin
      run_valid_r <= 1'b1;
      k_r         <= '0;
    end else if (done) begin
      run_valid_r <= 1'b0;
    end else if (emit) begin
      k_r <= k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_write_r <= load_is_write;
      run_req_r   <= load_req;
      run_byte_r  <= load_byte;
      run_index_r <= load_index;
      run_rgb_r   <= load_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_pal_r      <= (run_req_r.kind != KIND_DIRECT);
      res_oor_r      <= rd_oor;
      res_direct_r   <= run_req_r.direct;
      res_last_run_r <= last_k;
      res_last_row_r <= last_k && run_req_r.row_end;
    end
  end

  assign out_valid    = res_valid_r;
  assign out_pixel    = !res_pal_r ? res_direct_r :
                        res_oor_r  ? {ALPHA_OPAQUE, 24'h000000} : {ALPHA_OPAQUE, rdata};
  assign out_last_run = res_last_run_r;
  assign out_last_row = res_last_row_r;

endmodule

// File: hdl/bmp_line_pixel_unpacker.sv
// Top level of the BMP row pixel unpacker: configuration, handshakes and assertions.
`timescale 1ns / 1ps

// The block takes BMP pixel-row bytes and palette writes on the in_ channel
// and delivers 32-bit ARGB pixels on the out_ channel, both valid/ready.
// A request with in_op low carries one row byte; one with in_op high writes
// in_palette_rgb to palette entry in_palette_index. The cfg_ channel writes
// pixel_format (index 0) or line_width (index 1); either write restarts the
// row. The user must see that it is only issued while the block is idle;
// the block itself does not enforce this. cfg_ready is always high. A request
// passes through the run register and then the result register, from which
// its first pixel is offered on the out_ channel. Throughput: the run
// sequencer emits one pixel per cycle while the receiver does not stall it,
// since each palette pixel takes one read of the palette RAM. A byte holds
// the input until its last pixel is emitted, so 8 bpp and the direct formats
// take one byte per cycle while the output does not stall, and a 4 bpp or
// 1 bpp byte holds it while its pixels go out. Bytes that yield no pixel
// (padding, first bytes of a multi-byte pixel) skip the run register.
// While the receiver stalls, the finished pixel waits in the result register
// and the run register takes the next request behind it.
// Reset clears the row position and sets bgra32 with a one-pixel row; the
// palette holds nothing defined until its entries are written.

module bmp_line_pixel_unpacker #(
  parameter int MAX_WIDTH     = bmpu_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [bmpu_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [bmpu_pkg::BYTE_W-1:0]   in_palette_index,
  input  logic [bmpu_pkg::RGB_W-1:0]    in_palette_rgb,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmpu_pkg::ARGB_W-1:0]   out_pixel_argb,
  output logic                          out_last_of_run,
  output logic                          out_last_of_row,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [bmpu_pkg::LW_W-1:0]     cfg_data
);

  import bmpu_pkg::*;

  logic [FMT_W-1:0] pixel_format_r;
  logic [LW_W-1:0]  line_width_r;

  logic     cfg_write;
  logic     in_accept;
  logic     byte_accept;
  logic     can_load;
  logic     run_load;
  run_req_t req;

  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign in_ready    = can_load;
  assign in_accept   = in_valid && in_ready;
  assign byte_accept = in_accept && (in_op == OP_PIXEL);

  // Palette writes go through the run register too, so that they land in
  // order behind the palette reads of bytes accepted before them. Bytes that
  // yield no pixel only move the row position.
  assign run_load = in_accept && ((in_op == OP_PALETTE) || (req.count != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_BGRA32;
      line_width_r   <= LW_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: pixel_format_r <= cfg_data[FMT_W-1:0];
        CFG_LINE_WIDTH:   line_width_r   <= cfg_data;
      endcase
    end
  end

  bmpu_row_ctl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (cfg_write),
    .byte_accept  (byte_accept),
    .pixel_format (pixel_format_r),
    .line_width   (line_width_r),
    .data_byte    (in_data_byte),
    .req          (req)
  );

  bmpu_run_seq #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_run_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (run_load),
    .load_is_write (in_op == OP_PALETTE),
    .load_req      (req),
    .load_byte     (in_data_byte),
    .load_index    (in_palette_index),
    .load_rgb      (in_palette_rgb),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel_argb),
    .out_last_run  (out_last_of_run),
    .out_last_row  (out_last_of_row)
  );

  // The pixel that closes a row is always the last one of its byte.
  a_row_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_row |-> out_last_of_run)
    else $error("row end flagged on a pixel that is not last of its run");

  // The rest of a run follows without a gap once a pixel is taken.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("gap inside a multi-pixel run");

  // No pixel is offered right after reset.
  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// File: test/tb_top.sv
// Self-checking testbench of the BMP row pixel unpacker with a built-in pixel predictor.
`timescale 1ns / 1ps

// The testbench streams row bytes and palette writes into the unpacker and
// checks every pixel that comes back.
//
// An initial block plans the whole run. It writes both registers, then puts
// requests into pending_reqs and waits for the block to drain before it picks
// the next setting. A clocked driver takes requests from that queue and offers
// them on the in_ channel. A clocked monitor takes pixels from the out_
// channel. At each accepted request the driver runs the predictor, which keeps
// its own palette, row position and register copies. The predictor appends the
// pixels that the request must cause to awaited_pixels. The monitor compares
// each pixel, field by field, with the oldest entry in that queue.
//
// Palette entries are read only once they have been written. The generator
// tracks which entries hold a color and picks pixel bytes to match.
module tb_top;
  import bmpu_pkg::*;

  localparam int LONG_HOLD     = 300;   // receiver hold-off that fills the block
  localparam int SETTLE_CYCLES = 8;     // quiet time before a register write
  localparam int STUCK_LIMIT   = 3000;  // cycles without any handshake
  localparam int MAX_REPORTED  = 10;
  localparam int SETTINGS_RUN  = 6;     // random register settings

  // One request on the in_ channel.
  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  pal_idx;
    logic [RGB_W-1:0]   pal_rgb;
  } unpack_req_t;

  // One pixel that the block owes us.
  typedef struct packed {
    logic [ARGB_W-1:0] argb;
    logic              run_end;
    logic              row_end;
  } pixel_exp_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic                in_op            = 1'b0;
  logic [BYTE_W-1:0]   in_data_byte     = '0;
  logic [BYTE_W-1:0]   in_palette_index = '0;
  logic [RGB_W-1:0]    in_palette_rgb   = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [ARGB_W-1:0]   out_pixel_argb;
  logic                out_last_of_run;
  logic                out_last_of_row;
  logic                cfg_valid        = 1'b0;
  logic                cfg_ready;
  logic                cfg_index        = 1'b0;
  logic [LW_W-1:0]     cfg_data         = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bmp_line_pixel_unpacker i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .in_palette_index (in_palette_index),
    .in_palette_rgb   (in_palette_rgb),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_argb   (out_pixel_argb),
    .out_last_of_run  (out_last_of_run),
    .out_last_of_row  (out_last_of_row),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Queues between the planner, the driver and the monitor.
  unpack_req_t pending_reqs[$];
  pixel_exp_t  awaited_pixels[$];

  // Predictor state. It follows the block from reset: bgra32, one-pixel rows.
  logic [RGB_W-1:0]  palette_m [256];
  int unsigned       row_bytes = 0;
  int unsigned       row_pix   = 0;
  logic [RGB_W-1:0]  partial_m = '0;
  logic [1:0]        phase_m   = '0;
  logic [FMT_W-1:0]  fmt_m     = FMT_BGRA32;
  logic [LW_W-1:0]   width_m   = 13'd1;

  // Generator state: which palette entries hold a color so far.
  bit                pal_set [256];
  logic [BYTE_W-1:0] pal_used[$];
  logic [FMT_W-1:0]  gen_fmt = FMT_BGRA32;

  // Idle control: idle_pct is shared by both sides, hold_req drives the receiver.
  // The planner changes these on falling edges only, so the clocked processes never race with it.
  int idle_pct = 0;
  int hold_req = 0;

  int mismatch_count = 0;
  int stuck_cycles   = 0;

  // Width zero acts as one and anything past the maximum is clamped.
  function automatic int unsigned eff_width(logic [LW_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(w);
  endfunction

  // Code seven falls through to 32 bits, as bgra32.
  function automatic int unsigned fmt_bits(logic [FMT_W-1:0] f);
    case (f)
      FMT_1BPP:   return 1;
      FMT_4BPP:   return 4;
      FMT_8BPP:   return 8;
      FMT_RGB555: return 16;
      FMT_RGB565: return 16;
      FMT_BGR24:  return 24;
      default:    return 32;
    endcase
  endfunction

  // Bytes per row, padded out to whole 32-bit words.
  function automatic int unsigned row_stride(logic [FMT_W-1:0] f, logic [LW_W-1:0] w);
    return ((eff_width(w) * fmt_bits(f) + 31) / 32) * 4;
  endfunction

  function automatic logic [ARGB_W-1:0] palette_argb(logic [BYTE_W-1:0] idx);
    return {ALPHA_OPAQUE, palette_m[idx]};
  endfunction

  function automatic void restart_row();
    row_bytes = 0;
    row_pix   = 0;
    partial_m = '0;
    phase_m   = '0;
  endfunction

  // Works out the pixels that one accepted request causes and queues them.
  function automatic void derive_pixels(unpack_req_t r);
    logic [ARGB_W-1:0] pix [8];
    logic [ARGB_W-1:0] v;
    int                n;
    int unsigned       w;
    int unsigned       bpp;
    int unsigned       stride;
    int unsigned       nbytes;
    n = 0;
    if (r.op == OP_PALETTE) begin
      palette_m[r.pal_idx] = r.pal_rgb;
      return;
    end
    w      = eff_width(width_m);
    bpp    = fmt_bits(fmt_m);
    stride = row_stride(fmt_m, width_m);
    if (row_pix < w) begin
      case (bpp)
        1: begin
          // Most significant bit first, stopping where the row ends.
          for (int k = 7; k >= 0; k--) begin
            if (row_pix + n < w) begin
              pix[n] = palette_argb({7'd0, r.data_byte[k]});
              n++;
            end
          end
        end
        4: begin
          pix[0] = palette_argb({4'd0, r.data_byte[7:4]});
          n = 1;
          if (row_pix + 1 < w) begin
            pix[1] = palette_argb({4'd0, r.data_byte[3:0]});
            n = 2;
          end
        end
        8: begin
          pix[0] = palette_argb(r.data_byte);
          n = 1;
        end
        default: begin
          // Direct formats gather little-endian bytes until the pixel is whole.
          nbytes = bpp / 8;
          v = {8'd0, partial_m} | (ARGB_W'(r.data_byte) << (8 * phase_m));
          if (int'(phase_m) + 1 >= nbytes) begin
            case (fmt_m)
              FMT_RGB555: pix[0] = {ALPHA_OPAQUE, v[14:10], 3'b000, v[9:5], 3'b000,
                                    v[4:0], 3'b000};
              FMT_RGB565: pix[0] = {ALPHA_OPAQUE, v[15:11], 3'b000, v[10:5], 2'b00,
                                    v[4:0], 3'b000};
              FMT_BGR24:  pix[0] = {ALPHA_OPAQUE, v[23:0]};
              default:    pix[0] = v;
            endcase
            n = 1;
            partial_m = '0;
            phase_m   = '0;
          end else begin
            partial_m = v[RGB_W-1:0];
            phase_m   = phase_m + 2'd1;
          end
        end
      endcase
    end
    for (int k = 0; k < n; k++) begin
      row_pix++;
      awaited_pixels.push_back('{argb: pix[k], run_end: (k == n - 1), row_end: (row_pix == w)});
    end
    row_bytes++;
    if (row_bytes >= stride) restart_row();
  endfunction

  // Mostly no gap, now and then a short one, rarely a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A byte whose possible palette reads all hit written entries.
  function automatic logic [BYTE_W-1:0] pick_data_byte();
    logic [3:0] nib_ok[$];
    case (gen_fmt)
      FMT_4BPP: begin
        for (int i = 0; i < 16; i++) if (pal_set[i]) nib_ok.push_back(4'(i));
        return {nib_ok[$urandom_range(0, nib_ok.size() - 1)],
                nib_ok[$urandom_range(0, nib_ok.size() - 1)]};
      end
      FMT_8BPP: return pal_used[$urandom_range(0, pal_used.size() - 1)];
      default:  return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Unused fields of a request carry random values, since the block must
  // ignore them.
  function automatic void push_byte(logic [BYTE_W-1:0] b);
    unpack_req_t r;
    r.op        = OP_PIXEL;
    r.data_byte = b;
    r.pal_idx   = 8'($urandom_range(0, 255));
    r.pal_rgb   = 24'($urandom);
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_palette(logic [BYTE_W-1:0] idx, logic [RGB_W-1:0] rgb);
    unpack_req_t r;
    r.op        = OP_PALETTE;
    r.data_byte = 8'($urandom_range(0, 255));
    r.pal_idx   = idx;
    r.pal_rgb   = rgb;
    pending_reqs.push_back(r);
    pal_set[idx] = 1'b1;
    pal_used.push_back(idx);
  endfunction

  // Returns once every request has gone in, every pixel has come out and the
  // block has had time to finish bytes that yield no pixel.
  task automatic drain_and_settle();
    while (pending_reqs.size() != 0 || in_valid || awaited_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [LW_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Both registers for the next stretch of requests. The bits of the format
  // write above the code are junk and must be ignored.
  task automatic new_setting(logic [FMT_W-1:0] f, logic [LW_W-1:0] w);
    drain_and_settle();
    write_reg(CFG_PIXEL_FORMAT, {10'($urandom_range(0, 1023)), f});
    write_reg(CFG_LINE_WIDTH, w);
    @(negedge clk);
    gen_fmt = f;
  endtask

  // Driver: offers the oldest pending request, holds it until accepted, and
  // runs the predictor on the edge where it goes in.
  unpack_req_t cur_req;
  int          send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) derive_pixels(cur_req);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_op            <= cur_req.op;
          in_data_byte     <= cur_req.data_byte;
          in_palette_index <= cur_req.pal_idx;
          in_palette_rgb   <= cur_req.pal_rgb;
          in_valid         <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Register writes restart the row in the predictor just as in the block.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PIXEL_FORMAT) fmt_m = cfg_data[FMT_W-1:0];
      else width_m = cfg_data;
      restart_row();
    end
  end

  // Receiver: random stalls, plus one long hold-off each time the planner
  // bumps hold_req. The hold-off is counted here.
  int stall_left = 0;
  int hold_seen  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (hold_req != hold_seen) begin
      hold_seen  = hold_req;
      stall_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Monitor: every accepted pixel must match the oldest awaited one.
  pixel_exp_t exp_pix;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("tb_top: unexpected pixel %h run_end %b row_end %b",
                   out_pixel_argb, out_last_of_run, out_last_of_row);
      end else begin
        exp_pix = awaited_pixels.pop_front();
        if (out_pixel_argb !== exp_pix.argb || out_last_of_run !== exp_pix.run_end ||
            out_last_of_row !== exp_pix.row_end) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("tb_top: pixel mismatch: expected %h/%b/%b, got %h/%b/%b",
                     exp_pix.argb, exp_pix.run_end, exp_pix.row_end,
                     out_pixel_argb, out_last_of_run, out_last_of_row);
        end
      end
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    logic [FMT_W-1:0] fmt_sel;
    logic [LW_W-1:0]  width_sel;
    int unsigned      stride;
    int               n_bytes;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting, bgra32 with one-pixel rows: four bytes make one pixel
    // that closes its row.
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h5A); push_byte(8'hA5);

    // Palette entries at both ends of the index range.
    push_palette(8'd0, 24'h000000);
    push_palette(8'd1, 24'hFFFFFF);
    push_palette(8'd15, 24'hA5C3E1);
    push_palette(8'd128, 24'h5A3C1E);
    push_palette(8'd255, 24'h123456);

    // 1 bpp, ten pixels: the second byte is cut short at the row end, and
    // the last two bytes are padding.
    new_setting(FMT_1BPP, 13'd10);
    push_byte(8'hA5); push_byte(8'h5A); push_byte(8'hFF); push_byte(8'h00);

    // 4 bpp, three pixels: the second byte gives only its high nibble.
    new_setting(FMT_4BPP, 13'd3);
    push_byte(8'h1F); push_byte(8'hF0); push_byte(8'h00); push_byte(8'hFF);

    // 8 bpp with width zero, which acts as one pixel per row.
    new_setting(FMT_8BPP, 13'd0);
    push_byte(8'hFF); push_byte(8'h80);

    // RGB555 with the unused top bit set, then RGB565 with green alone.
    new_setting(FMT_RGB555, 13'd1);
    push_byte(8'hFF); push_byte(8'hFF);
    new_setting(FMT_RGB565, 13'd1);
    push_byte(8'hE0); push_byte(8'h07);

    new_setting(FMT_BGR24, 13'd1);
    push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);

    // Format code seven behaves as bgra32, here at the largest legal width.
    new_setting(3'd7, 13'd4096);
    push_byte(8'hDE); push_byte(8'hAD); push_byte(8'hBE); push_byte(8'hEF);

    // Random settings: whole rows with random content, a partial row at the
    // end, and palette writes mixed in.
    for (int ph = 0; ph < SETTINGS_RUN; ph++) begin
      fmt_sel = (ph == 0) ? FMT_BGRA32 : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       width_sel = 13'd0;
        1:       width_sel = 13'($urandom_range(4096, 8191));
        2:       width_sel = 13'($urandom_range(21, 40));
        default: width_sel = 13'($urandom_range(1, 20));
      endcase
      new_setting(fmt_sel, width_sel);
      idle_pct = (ph == 0) ? 0 : 30 * $urandom_range(0, 2);
      stride = row_stride(fmt_sel, width_sel);
      if (eff_width(width_sel) >= MAX_WIDTH_DEF)
        n_bytes = $urandom_range(4, 12);
      else
        n_bytes = stride * $urandom_range(1, 2) + $urandom_range(0, stride - 1);
      for (int i = 0; i < n_bytes; i++) begin
        // Now and then the sender waits for every pixel before going on.
        if (i == n_bytes / 2 && ph % 4 == 1) drain_and_settle();
        if ($urandom_range(0, 9) == 0)
          push_palette(8'($urandom_range(0, 255)), 24'($urandom));
        push_byte(pick_data_byte());
      end
      if ($urandom_range(0, 5) == 0) hold_req++;
    end

    // The start of a row at the clamped maximum width, 1 bpp, with the
    // receiver held off so that the block fills and stalls its input.
    new_setting(FMT_1BPP, 13'd8191);
    idle_pct = 10;
    for (int i = 0; i < 48; i++) push_byte(pick_data_byte());
    hold_req++;

    drain_and_settle();
    if (mismatch_count == 0 && awaited_pixels.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
